// ----- design/aaq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aaq_pkg
// Shared types, constants and tables for the axis-angle to quaternion block.
// ----------------------------------------------------------------------------
package aaq_pkg;

    // port field width, 16 to 64; the core works on 32-bit values
    localparam int DATA_WIDTH   = 32;
    localparam int THR_W        = 29;
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int DIV_BITS     = 31;
    localparam int CW           = 36;   // cordic datapath width

    localparam logic signed [CW-1:0] ONE_Q30     = 36'sd1073741824;
    localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [CW-1:0] GAIN_Q30    = 36'sd652032874;
    localparam logic [THR_W-1:0]     THR_RESET   = 29'd1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] rot_x;
        logic signed [DATA_WIDTH-1:0] rot_y;
        logic signed [DATA_WIDTH-1:0] rot_z;
    } in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quat_w;
        logic signed [DATA_WIDTH-1:0] quat_x;
        logic signed [DATA_WIDTH-1:0] quat_y;
        logic signed [DATA_WIDTH-1:0] quat_z;
        logic                         identity_taken;
    } out_t;

    // arctangent table in q.30, tail entries are 2^(30-i)
    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0: r = 36'sd843314857;
            1: r = 36'sd497837829;
            2: r = 36'sd263043837;
            3: r = 36'sd133525159;
            4: r = 36'sd67021687;
            5: r = 36'sd33543516;
            6: r = 36'sd16775851;
            7: r = 36'sd8388437;
            8: r = 36'sd4194283;
            9: r = 36'sd2097149;
            default: r = CW'(64'sd1 <<< (30 - i));
        endcase
        return r;
    endfunction

    // clamp a port field into the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [DATA_WIDTH-1:0] v);
        logic signed [63:0] e;
        logic signed [31:0] r;
        e = 64'(v);
        if (e > 64'sd2147483647)       r = 32'sh7fffffff;
        else if (e < -64'sd2147483648) r = 32'sh80000000;
        else                           r = e[31:0];
        return r;
    endfunction

    // sign-extend or truncate a 32-bit result to the port width
    function automatic logic signed [DATA_WIDTH-1:0] to_port(input logic signed [31:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        return e[DATA_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/aaq_isqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aaq_isqrt
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module aaq_isqrt #(
    parameter int SIDE_W = 96
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [63:0]       in_n,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [31:0]            out_root,
    output logic [SIDE_W-1:0]      out_side
);
    localparam int N = aaq_pkg::SQRT_STEPS;

    logic              v_reg    [0:N];
    logic [63:0]       n_reg    [0:N];
    logic [63:0]       res_reg  [0:N];
    logic [SIDE_W-1:0] side_reg [0:N];

    always_comb begin
        v_reg[0]    = in_valid;
        n_reg[0]    = in_n;
        res_reg[0]  = '0;
        side_reg[0] = in_side;
    end

    for (genvar k = 1; k <= N; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (64 - 2 * k);
        logic [63:0] sum;
        logic [63:0] n_next;
        logic [63:0] res_next;

        always_comb begin
            sum = res_reg[k-1] + BIT;
            if (n_reg[k-1] >= sum) begin
                n_next   = n_reg[k-1] - sum;
                res_next = (res_reg[k-1] >> 1) + BIT;
            end else begin
                n_next   = n_reg[k-1];
                res_next = res_reg[k-1] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k]    <= n_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_root  = res_reg[N][31:0];
    assign out_side  = side_reg[N];

endmodule
`default_nettype wire

// ----- design/aaq_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aaq_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module aaq_div #(
    parameter int SIDE_W = 36
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [62:0]       in_num [0:2],
    input  wire logic [31:0]       in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [aaq_pkg::DIV_BITS-1:0] out_q [0:2],
    output logic [SIDE_W-1:0]      out_side
);
    localparam int N = aaq_pkg::DIV_BITS;

    logic              v_reg    [0:N];
    logic [62:0]       r_reg    [0:N][0:2];
    logic [N-1:0]      q_reg    [0:N][0:2];
    logic [31:0]       den_reg  [0:N];
    logic [SIDE_W-1:0] side_reg [0:N];

    always_comb begin
        v_reg[0]    = in_valid;
        den_reg[0]  = in_den;
        side_reg[0] = in_side;
        for (int l = 0; l < 3; l++) begin
            r_reg[0][l] = in_num[l];
            q_reg[0][l] = '0;
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_stage
        localparam int J = N - k;
        logic [62:0]  dsh;
        logic [62:0]  r_next [0:2];
        logic [N-1:0] q_next [0:2];

        always_comb begin
            dsh = 63'(den_reg[k-1]) << J;
            for (int l = 0; l < 3; l++) begin
                if (r_reg[k-1][l] >= dsh) begin
                    r_next[l] = r_reg[k-1][l] - dsh;
                    q_next[l] = q_reg[k-1][l] | (N'(1) << J);
                end else begin
                    r_next[l] = r_reg[k-1][l];
                    q_next[l] = q_reg[k-1][l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
                for (int l = 0; l < 3; l++) begin
                    r_reg[k][l] <= r_next[l];
                    q_reg[k][l] <= q_next[l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) out_q[l] = q_reg[N][l];
    end
    assign out_valid = v_reg[N];
    assign out_side  = side_reg[N];

endmodule
`default_nettype wire

// ----- design/axis_angle_to_quaternion_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_to_quaternion_top
// Rotation vector (q3.28) to inverse-rotation unit quaternion (q1.30).
// ----------------------------------------------------------------------------
// throughput: one transfer per cycle; set by the fully pipelined square root,
//   cordic and divider, all stages advance together and stall together
// reset: aresetn synchronous active low, clears all valid bits and sets the
//   small-angle threshold to 1
// ----------------------------------------------------------------------------
module axis_angle_to_quaternion_top (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire aaq_pkg::in_t              s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output aaq_pkg::out_t                  m_data,
    input  wire logic                      cfg_we,
    input  wire logic [aaq_pkg::THR_W-1:0] cfg_wdata
);
    localparam int CW = aaq_pkg::CW;
    localparam int NC = aaq_pkg::CORDIC_STEPS;

    // whole pipeline moves when the output register is free or being drained
    logic en;
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    // small-angle threshold register
    logic [aaq_pkg::THR_W-1:0] thr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= aaq_pkg::THR_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // stage 1: clamp inputs to 32 bits
    logic               v1_reg;
    logic signed [31:0] c1_reg [0:2];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg[0] <= aaq_pkg::sat32(s_data.rot_x);
            c1_reg[1] <= aaq_pkg::sat32(s_data.rot_y);
            c1_reg[2] <= aaq_pkg::sat32(s_data.rot_z);
        end
    end

    // stage 2: squares of the magnitudes, exact in q.56
    logic               v2_reg;
    logic signed [31:0] c2_reg  [0:2];
    logic [63:0]        sq2_reg [0:2];
    logic [31:0]        a1      [0:2];
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            a1[l] = c1_reg[l][31] ? 32'(-c1_reg[l]) : 32'(c1_reg[l]);
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                c2_reg[l]  <= c1_reg[l];
                sq2_reg[l] <= 64'(a1[l]) * 64'(a1[l]);
            end
        end
    end

    // stage 3: sum of squares, fits 64 bits unsigned
    logic        v3_reg;
    logic [95:0] c3_reg;
    logic [63:0] sum3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            c3_reg   <= {c2_reg[0], c2_reg[1], c2_reg[2]};
            sum3_reg <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
        end
    end

    // square root: theta in q.28
    logic        vs;
    logic [31:0] theta_s;
    logic [95:0] cs;
    aaq_isqrt #(.SIDE_W(96)) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_n      (sum3_reg),
        .in_side   (c3_reg),
        .out_valid (vs),
        .out_root  (theta_s),
        .out_side  (cs)
    );

    // prep stage: threshold test, half angle theta/2 in q.30, range reduction
    logic              vp_reg;
    logic [95:0]       cp_reg;
    logic [31:0]       thp_reg;
    logic              idp_reg;
    logic signed [CW-1:0] zp_reg;
    logic              fdp_reg;
    logic signed [CW-1:0] z_a;
    logic signed [CW-1:0] z_b;
    logic              fold_b;
    always_comb begin
        z_a = CW'({theta_s, 1'b0});
        if (z_a > aaq_pkg::PI_Q30) z_a = z_a - aaq_pkg::TWO_PI_Q30;
        priority if (z_a > aaq_pkg::HALF_PI_Q30) begin
            z_b    = z_a - aaq_pkg::PI_Q30;
            fold_b = 1'b1;
        end else if (z_a < -aaq_pkg::HALF_PI_Q30) begin
            z_b    = z_a + aaq_pkg::PI_Q30;
            fold_b = 1'b1;
        end else begin
            z_b    = z_a;
            fold_b = 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
        end else if (en) begin
            vp_reg <= vs;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            cp_reg  <= cs;
            thp_reg <= theta_s;
            idp_reg <= theta_s <= 32'(thr_reg);
            zp_reg  <= z_b;
            fdp_reg <= fold_b;
        end
    end

    // cordic, rotation mode, one micro-rotation per stage
    logic                 cv_reg  [0:NC];
    logic signed [CW-1:0] cx_reg  [0:NC];
    logic signed [CW-1:0] cy_reg  [0:NC];
    logic signed [CW-1:0] cz_reg  [0:NC];
    logic [95:0]          cc_reg  [0:NC];
    logic [31:0]          cth_reg [0:NC];
    logic                 cid_reg [0:NC];
    logic                 cfd_reg [0:NC];
    always_comb begin
        cv_reg[0]  = vp_reg;
        cx_reg[0]  = aaq_pkg::GAIN_Q30;
        cy_reg[0]  = '0;
        cz_reg[0]  = zp_reg;
        cc_reg[0]  = cp_reg;
        cth_reg[0] = thp_reg;
        cid_reg[0] = idp_reg;
        cfd_reg[0] = fdp_reg;
    end
    for (genvar i = 1; i <= NC; i++) begin : g_cordic
        localparam logic signed [CW-1:0] ATAN = aaq_pkg::atan_q30(i - 1);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [CW-1:0] z_next;
        always_comb begin
            xs = cx_reg[i-1] >>> (i - 1);
            ys = cy_reg[i-1] >>> (i - 1);
            if (!cz_reg[i-1][CW-1]) begin
                x_next = cx_reg[i-1] - ys;
                y_next = cy_reg[i-1] + xs;
                z_next = cz_reg[i-1] - ATAN;
            end else begin
                x_next = cx_reg[i-1] + ys;
                y_next = cy_reg[i-1] - xs;
                z_next = cz_reg[i-1] + ATAN;
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[i] <= 1'b0;
            end else if (en) begin
                cv_reg[i] <= cv_reg[i-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                cx_reg[i]  <= x_next;
                cy_reg[i]  <= y_next;
                cz_reg[i]  <= z_next;
                cc_reg[i]  <= cc_reg[i-1];
                cth_reg[i] <= cth_reg[i-1];
                cid_reg[i] <= cid_reg[i-1];
                cfd_reg[i] <= cfd_reg[i-1];
            end
        end
    end

    // post stage: undo the fold, saturate w, split signs and magnitudes
    logic                 vq_reg;
    logic signed [31:0]   wq_reg;
    logic [31:0]          sq_mag_reg;
    logic                 sq_neg_reg;
    logic [95:0]          cq_reg;
    logic [31:0]          thq_reg;
    logic                 idq_reg;
    logic signed [CW-1:0] xf;
    logic signed [CW-1:0] yf;
    logic signed [CW-1:0] wsat;
    always_comb begin
        xf = cfd_reg[NC] ? -cx_reg[NC] : cx_reg[NC];
        yf = cfd_reg[NC] ? -cy_reg[NC] : cy_reg[NC];
        priority if (xf > aaq_pkg::ONE_Q30)   wsat = aaq_pkg::ONE_Q30;
        else if (xf < -aaq_pkg::ONE_Q30)      wsat = -aaq_pkg::ONE_Q30;
        else                                  wsat = xf;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vq_reg <= 1'b0;
        end else if (en) begin
            vq_reg <= cv_reg[NC];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            wq_reg     <= wsat[31:0];
            sq_mag_reg <= yf[CW-1] ? 32'(-yf) : 32'(yf);
            sq_neg_reg <= yf[CW-1];
            cq_reg     <= cc_reg[NC];
            thq_reg    <= cth_reg[NC];
            idq_reg    <= cid_reg[NC];
        end
    end

    // multiply stage: |c| * |sin|
    logic               vm_reg;
    logic [63:0]        mm_reg [0:2];
    logic [2:0]         ngm_reg;
    logic signed [31:0] wm_reg;
    logic [31:0]        thm_reg;
    logic               idm_reg;
    logic signed [31:0] cq   [0:2];
    logic [31:0]        cmag [0:2];
    always_comb begin
        cq[0] = cq_reg[95:64];
        cq[1] = cq_reg[63:32];
        cq[2] = cq_reg[31:0];
        for (int l = 0; l < 3; l++) begin
            cmag[l] = cq[l][31] ? 32'(-cq[l]) : 32'(cq[l]);
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
        end else if (en) begin
            vm_reg <= vq_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                mm_reg[l]  <= 64'(cmag[l]) * 64'(sq_mag_reg);
                // vector part is negated when both signs agree
                ngm_reg[l] <= cq[l][31] == sq_neg_reg;
            end
            wm_reg  <= wq_reg;
            thm_reg <= thq_reg;
            idm_reg <= idq_reg;
        end
    end

    // rounding stage: add theta/2, flag quotients of 2^31 and up
    logic         vh_reg;
    logic [62:0]  nh_reg [0:2];
    logic [2:0]   ovh_reg;
    logic [31:0]  thh_reg;
    logic [35:0]  sideh_reg;
    logic [64:0]  num  [0:2];
    logic [64:0]  dlim;
    always_comb begin
        dlim = {2'b0, thm_reg, 31'b0};
        for (int l = 0; l < 3; l++) num[l] = 65'(mm_reg[l]) + 65'(thm_reg >> 1);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vh_reg <= 1'b0;
        end else if (en) begin
            vh_reg <= vm_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                nh_reg[l]  <= num[l][62:0];
                ovh_reg[l] <= num[l] >= dlim;
            end
            thh_reg   <= thm_reg;
            sideh_reg <= {wm_reg, idm_reg, ngm_reg};
        end
    end

    // division by theta; overflowed lanes saturate afterwards anyway
    logic                          vd;
    logic [aaq_pkg::DIV_BITS-1:0]  qd [0:2];
    logic [38:0]                   sided;
    aaq_div #(.SIDE_W(39)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vh_reg),
        .in_num    (nh_reg),
        .in_den    (thh_reg),
        .in_side   ({sideh_reg, ovh_reg}),
        .out_valid (vd),
        .out_q     (qd),
        .out_side  (sided)
    );

    // output stage: clamp, apply sign, or return the identity
    logic               wd;
    logic signed [31:0] wd_w;
    logic [2:0]         ngd;
    logic [2:0]         ovd;
    logic signed [31:0] vec [0:2];
    logic [31:0]        qc;
    assign wd_w = sided[38:7];
    assign wd   = sided[6];
    assign ngd  = sided[5:3];
    assign ovd  = sided[2:0];
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            qc = (ovd[l] || 32'(qd[l]) > 32'd1073741824) ? 32'd1073741824 : 32'(qd[l]);
            vec[l] = ngd[l] ? -$signed(qc) : $signed(qc);
        end
    end

    logic m_valid_reg;
    aaq_pkg::out_t m_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vd;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            if (wd) begin
                m_data_reg.quat_w <= aaq_pkg::to_port(32'sd1073741824);
                m_data_reg.quat_x <= '0;
                m_data_reg.quat_y <= '0;
                m_data_reg.quat_z <= '0;
            end else begin
                m_data_reg.quat_w <= aaq_pkg::to_port(wd_w);
                m_data_reg.quat_x <= aaq_pkg::to_port(vec[0]);
                m_data_reg.quat_y <= aaq_pkg::to_port(vec[1]);
                m_data_reg.quat_z <= aaq_pkg::to_port(vec[2]);
            end
            m_data_reg.identity_taken <= wd;
        end
    end
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // identity results carry w = 1.0 and a zero vector part
    a_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.identity_taken) |->
        (m_data.quat_x == '0 && m_data.quat_y == '0 && m_data.quat_z == '0))
        else $error("identity result with nonzero vector part");

    // a stalled result is never overwritten by the pipeline
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    // input side stalls exactly when the output is blocked
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (m_ready || !m_valid))
        else $error("input ready out of step with output stall");

endmodule
`default_nettype wire
